// ===== src/csp_pkg.sv =====
// csp_pkg: shared types and constants for the character screen port
// no dependencies

package csp_pkg;

    typedef logic [2:0] step_t;

    localparam step_t STEP_ROW    = 3'd0;
    localparam step_t STEP_COL    = 3'd1;
    localparam step_t STEP_MODE   = 3'd2;
    localparam step_t STEP_COLOUR = 3'd3;
    localparam step_t STEP_SYMBOL = 3'd4;

    localparam logic [7:0] SPACE_CODE = 8'd32;
    localparam logic [5:0] COLOUR_MAX = 6'd63;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_COLOUR,
        RD_SYMBOL
    } rd_kind_t;

endpackage

// ===== src/char_screen_port.sv =====
// char_screen_port: character screen behind a byte-wide port, symbol and colour memories
// depends on csp_pkg

// A ROWS by COLS screen of 8-bit symbols and 6-bit colours in two synchronous memories.
// Port writes walk a five-step sequence (row, column, mode, colour, symbol); the symbol
// write in write mode stores one cell. Every port read gives one result: the colour at
// step four, the symbol at step five in read mode, zero otherwise. A write may be taken
// while a result waits at the output. A read returns its result through the memory
// read register and then the output register; a read is taken only with the output
// register free or being emptied, and not in the cycle right after another read. After
// reset a clearing pass fills the screen with spaces and colour zero; no request is
// taken during it.

module char_screen_port #(
    parameter int ROWS = 20,
    parameter int COLS = 20
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data
);

    localparam int CELLS = ROWS * COLS;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [7:0]        sym_mem [CELLS];
    logic [5:0]        col_mem [CELLS];

    logic              clearing_reg;
    logic [AW-1:0]     clr_idx_reg;
    csp_pkg::step_t    step_reg, step_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic              mode_reg, mode_next;
    logic [5:0]        pcol_reg, pcol_next;
    logic              pend_reg;
    csp_pkg::rd_kind_t pend_kind_reg, pend_kind_next;
    logic              out_valid_reg;
    logic [7:0]        read_data_reg, read_data_next;
    logic [7:0]        sym_q_reg;
    logic [5:0]        col_q_reg;

    logic              accept;
    logic              mem_rd;
    logic              mem_wr;
    logic [AW-1:0]     cell_addr;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_sym;
    logic [5:0]        wr_col;
    logic [7:0]        sym_in;

    assign in_ready  = !clearing_reg
                     && (!op || (!pend_reg && (!out_valid_reg || out_ready)));
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    assign cell_addr = AW'(AW'(row_reg) * AW'(COLS)) + AW'(col_reg);
    assign sym_in    = (data > csp_pkg::SPACE_CODE) ? data : csp_pkg::SPACE_CODE;

    // sequence step logic
    always_comb
    begin
        step_next      = step_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        mode_next      = mode_reg;
        pcol_next      = pcol_reg;
        pend_kind_next = csp_pkg::RD_ZERO;
        mem_rd         = 1'b0;
        mem_wr         = 1'b0;
        if (accept)
        begin
            if (!op)
            begin
                unique case (step_reg)
                    csp_pkg::STEP_ROW:
                    begin
                        row_next  = (data > 8'(ROWS - 1)) ? RW'(ROWS - 1) : data[RW-1:0];
                        step_next = csp_pkg::STEP_COL;
                    end
                    csp_pkg::STEP_COL:
                    begin
                        col_next  = (data > 8'(COLS - 1)) ? CW'(COLS - 1) : data[CW-1:0];
                        step_next = csp_pkg::STEP_MODE;
                    end
                    csp_pkg::STEP_MODE:
                    begin
                        mode_next = (data != 8'd0);
                        step_next = csp_pkg::STEP_COLOUR;
                    end
                    csp_pkg::STEP_COLOUR:
                    begin
                        pcol_next = (data > {2'b00, csp_pkg::COLOUR_MAX})
                                  ? csp_pkg::COLOUR_MAX : data[5:0];
                        step_next = csp_pkg::STEP_SYMBOL;
                    end
                    default:
                    begin
                        mem_wr    = !mode_reg;
                        step_next = csp_pkg::STEP_ROW;
                    end
                endcase
            end
            else
            begin
                unique case (step_reg)
                    csp_pkg::STEP_COLOUR:
                    begin
                        mem_rd         = mode_reg;
                        pend_kind_next = mode_reg ? csp_pkg::RD_COLOUR : csp_pkg::RD_ZERO;
                        step_next      = csp_pkg::STEP_SYMBOL;
                    end
                    csp_pkg::STEP_SYMBOL:
                    begin
                        mem_rd         = mode_reg;
                        pend_kind_next = mode_reg ? csp_pkg::RD_SYMBOL : csp_pkg::RD_ZERO;
                        step_next      = csp_pkg::STEP_ROW;
                    end
                    default:
                    begin
                        step_next = step_reg + 3'd1;
                    end
                endcase
            end
        end
    end

    // clearing pass shares the write port
    always_comb
    begin
        if (clearing_reg)
        begin
            wr_addr = clr_idx_reg;
            wr_sym  = csp_pkg::SPACE_CODE;
            wr_col  = 6'd0;
        end
        else
        begin
            wr_addr = cell_addr;
            wr_sym  = sym_in;
            wr_col  = pcol_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg || mem_wr)
        begin
            sym_mem[wr_addr] <= wr_sym;
            col_mem[wr_addr] <= wr_col;
        end
        if (mem_rd)
        begin
            sym_q_reg <= sym_mem[cell_addr];
            col_q_reg <= col_mem[cell_addr];
        end
    end

    always_comb
    begin
        unique case (pend_kind_reg)
            csp_pkg::RD_COLOUR: read_data_next = {2'b00, col_q_reg};
            csp_pkg::RD_SYMBOL: read_data_next = sym_q_reg;
            default:            read_data_next = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            step_reg      <= csp_pkg::STEP_ROW;
            row_reg       <= '0;
            col_reg       <= '0;
            mode_reg      <= 1'b0;
            pcol_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_kind_reg <= csp_pkg::RD_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
                if (clr_idx_reg == AW'(CELLS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            step_reg <= step_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            mode_reg <= mode_next;
            pcol_reg <= pcol_next;
            pend_reg <= accept && op;
            if (accept && op)
            begin
                pend_kind_reg <= pend_kind_next;
            end
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            read_data_reg <= read_data_next;
        end
    end

endmodule

// ===== src/csp_checker.sv =====
// csp_checker: port-level assertions for the character screen port, bound to the top level
// depends on char_screen_port

module csp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       op,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data))
        else $error("result changed while stalled");

    // each read request shows its result through the memory read and output registers
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op |-> ##2 out_valid)
        else $error("read request without result");

    // no read request right behind another
    a_read_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op |=> !(in_valid && in_ready && op))
        else $error("back to back read requests");

    // a read is taken only with room at the output
    a_read_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op |-> !out_valid || out_ready)
        else $error("read request taken with output full");

endmodule

bind char_screen_port csp_checker u_csp_checker (.*);
